// ----- rtl/core/uart8n1_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// UART 8N1 package
// Shared widths, reset values and bit-index codes for the UART transceiver.
// ----------------------------------------------------------------------------
package uart8n1_pkg;

    // frame format
    localparam int DATA_BITS  = 8;
    localparam int TICK_WIDTH = 16;
    localparam int SHIFT_W    = DATA_BITS + 1;
    localparam int IDX_W      = 4;

    typedef logic [TICK_WIDTH-1:0] tick_t;
    typedef logic [IDX_W-1:0]      bit_idx_t;
    typedef logic [DATA_BITS-1:0]  data_t;
    typedef logic [SHIFT_W-1:0]    tx_shift_t;

    // bit-period register
    localparam tick_t PERIOD_RESET = tick_t'(434);
    localparam tick_t PERIOD_MIN   = tick_t'(2);

    // positions within a frame
    localparam bit_idx_t IDX_START      = bit_idx_t'(0);
    localparam bit_idx_t IDX_FIRST_DATA = bit_idx_t'(1);
    localparam bit_idx_t IDX_LAST_DATA  = bit_idx_t'(DATA_BITS);
    localparam bit_idx_t IDX_STOP       = bit_idx_t'(DATA_BITS + 1);

    // idle transmit shift pattern
    localparam tx_shift_t TX_SHIFT_IDLE = '1;

endpackage : uart8n1_pkg
`default_nettype wire

// ----- rtl/core/uart_8n1_transceiver_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// UART 8N1 transceiver
// Bit-period timed transmitter and mid-bit sampling receiver, one tick per item.
// ----------------------------------------------------------------------------
// Each input item is one tick of the bit timebase: the sampled receive line
// and an optional byte to send. The block takes one item every clock cycle
// and returns one result item per input item in the cycle after acceptance,
// from a single result register; in_ready is high while it is empty or being
// drained, so the sustained rate is one item per cycle. Data goes LSB first
// with a low start bit and a high stop bit, each bit_period ticks long
// (values below 2 act as 2). The receiver starts on a falling edge of an
// idle line, samples each data bit at its middle and presents the byte at
// the middle of the stop bit, whose level is not checked. The user writes
// bit_period on the cfg channel while no items are in flight; not enforced.
module uart_8n1_transceiver_unit
    import uart8n1_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,
    // input items
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        rx_line,
    input  wire logic        tx_valid,
    input  wire logic [7:0]  tx_byte,
    // result items
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             tx_line,
    output logic             tx_ready,
    output logic             rx_valid,
    output logic [7:0]       rx_byte
);

    // configuration and state registers
    tick_t     bit_period_reg;
    tx_shift_t tx_shift_reg,      tx_shift_next;
    bit_idx_t  tx_bit_index_reg,  tx_bit_index_next;
    tick_t     tx_tick_count_reg, tx_tick_count_next;
    logic      tx_busy_reg,       tx_busy_next;
    data_t     rx_shift_reg,      rx_shift_next;
    bit_idx_t  rx_bit_index_reg,  rx_bit_index_next;
    tick_t     rx_tick_count_reg, rx_tick_count_next;
    logic      rx_busy_reg,       rx_busy_next;
    logic      rx_line_prev_reg;

    // result register
    logic      out_valid_reg;
    logic      out_tx_line_reg,  out_tx_line_next;
    logic      out_tx_ready_reg, out_tx_ready_next;
    logic      out_rx_valid_reg, out_rx_valid_next;
    data_t     out_rx_byte_reg,  out_rx_byte_next;

    logic      in_accept;
    tick_t     period;
    tick_t     tx_tick_inc;
    tick_t     rx_tick_inc;
    tick_t     rx_target;

    // handshakes
    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    // effective bit period
    assign period      = (bit_period_reg < PERIOD_MIN) ? PERIOD_MIN : bit_period_reg;
    assign tx_tick_inc = tx_tick_count_reg + tick_t'(1);
    assign rx_tick_inc = rx_tick_count_reg + tick_t'(1);
    assign rx_target   = (rx_bit_index_reg == IDX_START) ? (period >> 1) : period;

    // transmitter next state
    always_comb
    begin
        tx_shift_next      = tx_shift_reg;
        tx_bit_index_next  = tx_bit_index_reg;
        tx_tick_count_next = tx_tick_count_reg;
        tx_busy_next       = tx_busy_reg;
        if (!tx_busy_reg)
        begin
            if (tx_valid)
            begin
                tx_shift_next      = {1'b1, tx_byte};
                tx_bit_index_next  = IDX_START;
                tx_tick_count_next = '0;
                tx_busy_next       = 1'b1;
            end
        end
        else if (tx_tick_inc >= period)
        begin
            tx_tick_count_next = '0;
            if (tx_bit_index_reg >= IDX_FIRST_DATA && tx_bit_index_reg <= IDX_LAST_DATA)
            begin
                tx_shift_next = {1'b1, tx_shift_reg[SHIFT_W-1:1]};
            end
            if (tx_bit_index_reg >= IDX_STOP)
            begin
                tx_busy_next      = 1'b0;
                tx_bit_index_next = IDX_START;
                tx_shift_next     = TX_SHIFT_IDLE;
            end
            else
            begin
                tx_bit_index_next = tx_bit_index_reg + bit_idx_t'(1);
            end
        end
        else
        begin
            tx_tick_count_next = tx_tick_inc;
        end
    end

    // transmit line level after this tick
    always_comb
    begin
        out_tx_line_next = 1'b1;
        if (tx_busy_next)
        begin
            if (tx_bit_index_next == IDX_START)
            begin
                out_tx_line_next = 1'b0;
            end
            else if (tx_bit_index_next <= IDX_LAST_DATA)
            begin
                out_tx_line_next = tx_shift_next[0];
            end
        end
    end

    // receiver next state
    always_comb
    begin
        rx_shift_next      = rx_shift_reg;
        rx_bit_index_next  = rx_bit_index_reg;
        rx_tick_count_next = rx_tick_count_reg;
        rx_busy_next       = rx_busy_reg;
        out_rx_valid_next  = 1'b0;
        out_rx_byte_next   = '0;
        if (!rx_busy_reg)
        begin
            if (rx_line_prev_reg && !rx_line)
            begin
                rx_busy_next       = 1'b1;
                rx_bit_index_next  = IDX_START;
                rx_tick_count_next = '0;
                rx_shift_next      = '0;
            end
        end
        else if (rx_tick_inc >= rx_target)
        begin
            rx_tick_count_next = '0;
            if (rx_bit_index_reg >= IDX_FIRST_DATA && rx_bit_index_reg <= IDX_LAST_DATA)
            begin
                rx_shift_next = {rx_line, rx_shift_reg[DATA_BITS-1:1]};
            end
            if (rx_bit_index_reg >= IDX_STOP)
            begin
                out_rx_valid_next = 1'b1;
                out_rx_byte_next  = rx_shift_reg;
                rx_busy_next      = 1'b0;
                rx_bit_index_next = IDX_START;
            end
            else
            begin
                rx_bit_index_next = rx_bit_index_reg + bit_idx_t'(1);
            end
        end
        else
        begin
            rx_tick_count_next = rx_tick_inc;
        end
    end

    assign out_tx_ready_next = !tx_busy_reg;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg <= PERIOD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            bit_period_reg <= cfg_data;
        end
    end

    // state update on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_shift_reg      <= TX_SHIFT_IDLE;
            tx_bit_index_reg  <= IDX_START;
            tx_tick_count_reg <= '0;
            tx_busy_reg       <= 1'b0;
            rx_shift_reg      <= '0;
            rx_bit_index_reg  <= IDX_START;
            rx_tick_count_reg <= '0;
            rx_busy_reg       <= 1'b0;
            rx_line_prev_reg  <= 1'b1;
        end
        else if (in_accept)
        begin
            tx_shift_reg      <= tx_shift_next;
            tx_bit_index_reg  <= tx_bit_index_next;
            tx_tick_count_reg <= tx_tick_count_next;
            tx_busy_reg       <= tx_busy_next;
            rx_shift_reg      <= rx_shift_next;
            rx_bit_index_reg  <= rx_bit_index_next;
            rx_tick_count_reg <= rx_tick_count_next;
            rx_busy_reg       <= rx_busy_next;
            rx_line_prev_reg  <= rx_line;
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_tx_line_reg  <= out_tx_line_next;
            out_tx_ready_reg <= out_tx_ready_next;
            out_rx_valid_reg <= out_rx_valid_next;
            out_rx_byte_reg  <= out_rx_byte_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign tx_line   = out_tx_line_reg;
    assign tx_ready  = out_tx_ready_reg;
    assign rx_valid  = out_rx_valid_reg;
    assign rx_byte   = out_rx_byte_reg;

`ifndef SYNTHESIS
    // idle transmitter holds an all-ones shift pattern at bit zero
    a_tx_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !tx_busy_reg |-> (tx_shift_reg == TX_SHIFT_IDLE && tx_bit_index_reg == IDX_START))
        else $error("transmitter idle with stale shift or index");

    // bit indexes never run past the stop bit
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (tx_bit_index_reg <= IDX_STOP) && (rx_bit_index_reg <= IDX_STOP))
        else $error("bit index beyond stop bit");

    // a stalled result blocks new items
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !in_ready)
        else $error("item accepted over a pending result");

    // a received byte closes the frame
    a_rx_done: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && out_rx_valid_next) |=> !rx_busy_reg)
        else $error("receiver still busy after delivering a byte");

    // an accepted offer on an idle transmitter starts a frame with a low start bit
    a_tx_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !tx_busy_reg && tx_valid) |=> (tx_busy_reg && !out_tx_line_reg))
        else $error("transmit frame did not start");
`endif

endmodule : uart_8n1_transceiver_unit
`default_nettype wire

// ----- tb/uart_8n1_transceiver_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART 8N1 transceiver checker
// Watches the cfg, input and result channels of the transceiver. It keeps its
// own copy of the transmit and receive state, works out the line levels each
// accepted tick should give, and compares every result item in order.
// ----------------------------------------------------------------------------
module uart_8n1_transceiver_checker
    import uart8n1_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic        rx_line,
    input  wire logic        tx_valid,
    input  wire logic [7:0]  tx_byte,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic        tx_line,
    input  wire logic        tx_ready,
    input  wire logic        rx_valid,
    input  wire logic [7:0]  rx_byte,
    output int               fail_count,
    output int               pending
);

    // one tick's worth of line levels
    typedef struct packed {
        logic  tx_line;
        logic  tx_ready;
        logic  rx_valid;
        data_t rx_byte;
    } line_levels_t;

    // bit-period register copy
    tick_t        period_reg;

    // transmitter state
    tx_shift_t    tx_shift;
    bit_idx_t     tx_idx;
    tick_t        tx_count;
    logic         tx_busy;

    // receiver state
    data_t        rx_shift;
    bit_idx_t     rx_idx;
    tick_t        rx_count;
    logic         rx_busy;
    logic         rx_prev;

    line_levels_t expected_levels[$];
    line_levels_t oldest;
    int           mismatches;

    // advance both directions by one tick and return the levels it gives
    function automatic line_levels_t step_uart(logic rx, logic offer, data_t value);
        line_levels_t res;
        tick_t        span;
        tick_t        target;
        tick_t        next;
        span = (period_reg < PERIOD_MIN) ? PERIOD_MIN : period_reg;
        res.tx_line  = 1'b1;
        res.tx_ready = !tx_busy;
        res.rx_valid = 1'b0;
        res.rx_byte  = '0;

        // transmitter: take a byte when idle, else count out the bit
        if (!tx_busy) begin
            if (offer) begin
                tx_shift = {1'b1, value};
                tx_idx   = IDX_START;
                tx_count = '0;
                tx_busy  = 1'b1;
            end
        end
        else begin
            next = tx_count + tick_t'(1);
            if (next >= span) begin
                tx_count = '0;
                if (tx_idx >= IDX_FIRST_DATA && tx_idx <= IDX_LAST_DATA)
                    tx_shift = {1'b1, tx_shift[SHIFT_W-1:1]};
                if (tx_idx >= IDX_STOP) begin
                    tx_busy  = 1'b0;
                    tx_idx   = IDX_START;
                    tx_shift = TX_SHIFT_IDLE;
                end
                else begin
                    tx_idx = tx_idx + bit_idx_t'(1);
                end
            end
            else begin
                tx_count = next;
            end
        end

        // line level after this tick
        if (tx_busy) begin
            if (tx_idx == IDX_START)
                res.tx_line = 1'b0;
            else if (tx_idx <= IDX_LAST_DATA)
                res.tx_line = tx_shift[0];
            else
                res.tx_line = 1'b1;
        end

        // receiver: start on a falling edge, then sample at mid-bit
        if (!rx_busy) begin
            if (rx_prev && !rx) begin
                rx_busy  = 1'b1;
                rx_idx   = IDX_START;
                rx_count = '0;
                rx_shift = '0;
            end
        end
        else begin
            target = (rx_idx == IDX_START) ? (span >> 1) : span;
            next   = rx_count + tick_t'(1);
            if (next >= target) begin
                rx_count = '0;
                if (rx_idx >= IDX_FIRST_DATA && rx_idx <= IDX_LAST_DATA)
                    rx_shift = {rx, rx_shift[DATA_BITS-1:1]};
                if (rx_idx >= IDX_STOP) begin
                    res.rx_valid = 1'b1;
                    res.rx_byte  = rx_shift;
                    rx_busy      = 1'b0;
                    rx_idx       = IDX_START;
                end
                else begin
                    rx_idx = rx_idx + bit_idx_t'(1);
                end
            end
            else begin
                rx_count = next;
            end
        end
        rx_prev = rx;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // predict on every accepted input item, compare on every accepted result item
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            period_reg = PERIOD_RESET;
            tx_shift   = TX_SHIFT_IDLE;
            tx_idx     = IDX_START;
            tx_count   = '0;
            tx_busy    = 1'b0;
            rx_shift   = '0;
            rx_idx     = IDX_START;
            rx_count   = '0;
            rx_busy    = 1'b0;
            rx_prev    = 1'b1;
            mismatches = 0;
            expected_levels.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready)
                period_reg = cfg_data;
            if (in_valid && in_ready)
                expected_levels.push_back(step_uart(rx_line, tx_valid, tx_byte));
            if (out_valid && out_ready) begin
                if (expected_levels.size() == 0) begin
                    $error("result item arrived with nothing expected");
                    mismatches++;
                end
                else begin
                    oldest = expected_levels.pop_front();
                    check_field("tx_line", 8'(oldest.tx_line), 8'(tx_line));
                    check_field("tx_ready", 8'(oldest.tx_ready), 8'(tx_ready));
                    check_field("rx_valid", 8'(oldest.rx_valid), 8'(rx_valid));
                    check_field("rx_byte", oldest.rx_byte, rx_byte);
                end
            end
            pending    <= expected_levels.size();
            fail_count <= mismatches;
        end
    end

endmodule

// ----- tb/tb_uart_8n1_transceiver_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART 8N1 transceiver testbench
// Drives tick items carrying serial frames, line noise and transmit offers
// through several bit-period settings and idling patterns; the checker beside
// the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_uart_8n1_transceiver_unit
    import uart8n1_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_TICKS    = 240;
    localparam int FRAME_BITS     = DATA_BITS + 2;
    localparam int FRAME_SPAN_MAX = 64;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic        rx_line   = 1'b1;
    logic        tx_valid  = 1'b0;
    logic [7:0]  tx_byte   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        tx_line;
    logic        tx_ready;
    logic        rx_valid;
    logic [7:0]  rx_byte;

    int fail_count;
    int pending;
    int idle_pct       = 0;
    int stall_pct      = 0;
    int quiet_cycles   = 0;
    int ticks_sent     = 0;
    int frames_driven  = 0;
    int bytes_received = 0;

    uart_8n1_transceiver_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_line   (rx_line),
        .tx_valid  (tx_valid),
        .tx_byte   (tx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .tx_line   (tx_line),
        .tx_ready  (tx_ready),
        .rx_valid  (rx_valid),
        .rx_byte   (rx_byte)
    );

    uart_8n1_transceiver_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_line    (rx_line),
        .tx_valid   (tx_valid),
        .tx_byte    (tx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .tx_line    (tx_line),
        .tx_ready   (tx_ready),
        .rx_valid   (rx_valid),
        .rx_byte    (rx_byte),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // result-side stalls
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // received bytes, for the summary
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready && rx_valid)
            bytes_received++;
    end

    // watchdog on cycles with no item moving on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (cfg_valid && cfg_ready) || (in_valid && in_ready)
            || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // one tick item; valid stays high afterwards unless the next call idles
    task automatic put_tick(input logic rx, input logic offer, input logic [7:0] value);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_line  <= rx;
        tx_valid <= offer;
        tx_byte  <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        ticks_sent++;
    endtask

    // stop sending and wait for every expected result item
    task automatic drain_items();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_period(input logic [15:0] value);
        drain_items();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one serial frame on the receive line, random transmit offers alongside
    task automatic drive_frame(input logic [7:0] value, input logic stop_level,
                               input bit start_glitch, input int unsigned span);
        logic level;
        for (int b = 0; b < FRAME_BITS; b++)
        begin
            for (int unsigned t = 0; t < span; t++)
            begin
                if (b == 0)
                    level = start_glitch && (t != 0);
                else if (b <= DATA_BITS)
                    level = value[b-1];
                else
                    level = stop_level;
                put_tick(level, $urandom_range(3) == 0, 8'($urandom_range(255)));
            end
        end
        frames_driven++;
    endtask

    // stimulus
    initial
    begin
        logic [15:0] period;
        int unsigned span;
        int unsigned kind;
        int unsigned gap;
        int          phase_start;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset period: offer, falling edge, offer while busy
        put_tick(1'b1, 1'b1, 8'hFF);
        put_tick(1'b0, 1'b0, 8'h00);
        put_tick(1'b0, 1'b1, 8'h00);
        put_tick(1'b1, 1'b0, 8'h5A);

        // zero period acts as the shortest; all-zero byte with a low stop bit
        write_period(16'd0);
        drive_frame(8'h00, 1'b0, 1'b0, 2);

        // random phases over periods and idling patterns
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            case (ph)
                0: period = 16'd2;
                1: period = 16'd3;
                2: period = 16'd5;
                3: period = 16'd10;
                4: period = 16'hFFFF;
                5: period = 16'd1;
                6: period = 16'd7;
                default: period = 16'd4;
            endcase
            write_period(period);
            span = (period < 16'd2) ? 2 : period;
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 56; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 56; end
                default: begin idle_pct = 29; stall_pct = 29; end
            endcase

            phase_start = ticks_sent;
            while (ticks_sent - phase_start < PHASE_TICKS)
            begin
                kind = $urandom_range(9);
                if (span > FRAME_SPAN_MAX || kind == 0)
                begin
                    // line noise, edges at random
                    repeat ($urandom_range(1, 16))
                        put_tick(1'($urandom_range(1)), $urandom_range(3) == 0,
                                 8'($urandom_range(255)));
                end
                else
                begin
                    // idle gap then a frame; some with a low stop or a short start
                    gap = $urandom_range(0, 2 * span);
                    repeat (gap)
                        put_tick(1'b1, $urandom_range(3) == 0, 8'($urandom_range(255)));
                    drive_frame(8'($urandom_range(255)), kind != 1, kind == 2, span);
                end
            end
        end

        drain_items();
        repeat (8) @(posedge clk);

        $display("%0d tick items over %0d bit-period settings and four idling patterns",
                 ticks_sent, PHASE_COUNT + 2);
        $display("%0d frames driven on the receive line, %0d bytes received",
                 frames_driven, bytes_received);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
